### hw/rtl/crdr_pkg.sv
// Package for the cross-coupled delay echo block.
// Holds field widths, the knob scale and the Q1.15 helper functions.
// No dependencies.
`default_nettype none

package crdr_pkg;

    // Payload widths of the stream fields.
    localparam int SAMPLE_W = 16;
    localparam int KNOB_W   = 16;

    // Knob scale: 1.0 in unsigned Q1.15, and its fraction bits.
    localparam int              KNOB_FRAC = 15;
    localparam logic [KNOB_W-1:0] KNOB_ONE = 16'h8000;

    // Default number of entries in each line.
    localparam int LINE_DEPTH_DEF = 22050;

    // Saturation limits of a Q1.15 sample.
    localparam logic signed [SAMPLE_W:0] SAT_MAX = 17'sh07FFF;
    localparam logic signed [SAMPLE_W:0] SAT_MIN = -17'sh08000;

    // Floor of half a sample, an arithmetic shift right by one.
    function automatic logic signed [SAMPLE_W-1:0] half_floor(
        input logic signed [SAMPLE_W-1:0] v
    );
        return {v[SAMPLE_W-1], v[SAMPLE_W-1:1]};
    endfunction

    // Sum of two samples, clipped to the 16-bit range.
    function automatic logic signed [SAMPLE_W-1:0] sat_add(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] sum;
        sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        if (sum > SAT_MAX) begin
            return SAT_MAX[SAMPLE_W-1:0];
        end else if (sum < SAT_MIN) begin
            return SAT_MIN[SAMPLE_W-1:0];
        end
        return sum[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cross_coupled_delay_reverb_top.sv
// Top level of the cross-coupled two-line delay echo.
// Depends on crdr_pkg, crdr_addr_gen and crdr_line_ram.
//
// Input beats on s_* carry a signed Q1.15 sample and an unsigned Q1.15
// delay knob; each beat gives exactly one output beat on m_* with the
// echoed sample. The delay is 1 + floor(knob * (LINE_DEPTH - 1)) samples.
// The pipeline takes one beat per clock while it is not stalled: three address
// stages, a registered RAM read, one mix stage that writes both lines back,
// then the output register.
// The only loop through state is the line RAMs; a read that lands on the
// entry written by the previous beat in the same cycle is forwarded.
// After reset both lines are swept to zero, one entry per clock;
// s_tready stays low until the sweep is done.
// When the receiver holds m_tready low with a beat waiting, the whole
// pipeline freezes and s_tready falls in that cycle; nothing is lost.
`default_nettype none

module cross_coupled_delay_reverb_top #(
    parameter int LINE_DEPTH = crdr_pkg::LINE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] sample_in, [31:16] delay_knob
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [15:0] sample_out
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int SW = crdr_pkg::SAMPLE_W;

    localparam logic [AW-1:0] POS_LAST = AW'(LINE_DEPTH - 1);

    logic en;
    logic in_accept;

    logic                 rd_valid;
    logic signed [SW-1:0] rd_sample;
    logic        [AW-1:0] rd_pos;
    logic        [AW-1:0] rd_idx;

    logic          clear_busy_reg;
    logic [AW-1:0] clear_cnt_reg;

    logic                 s4_valid_reg;
    logic signed [SW-1:0] s4_sample_reg;
    logic        [AW-1:0] s4_pos_reg;
    logic                 s4_self_hit_reg;
    logic                 s4_fwd_hit_reg;
    logic signed [SW-1:0] s4_fwd_fwd_reg;
    logic signed [SW-1:0] s4_fwd_ret_reg;

    logic [SW-1:0] fwd_rd_data;
    logic [SW-1:0] ret_rd_data;

    logic signed [SW-1:0] fwd_val;
    logic signed [SW-1:0] tap;
    logic signed [SW-1:0] ret_val;
    logic signed [SW-1:0] fwd_wdata;
    logic signed [SW-1:0] result;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] fwd_wr_data;
    logic [SW-1:0] ret_wr_data;

    logic          m_tvalid_reg;
    logic [SW-1:0] m_data_reg;

    // The pipeline moves whenever the output register is free or being drained.
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en && !clear_busy_reg;
    assign in_accept = s_tvalid && s_tready;

    crdr_addr_gen #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_addr_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_accept (in_accept),
        .in_sample (s_tdata[15:0]),
        .in_knob   (s_tdata[31:16]),
        .rd_valid  (rd_valid),
        .rd_sample (rd_sample),
        .rd_pos    (rd_pos),
        .rd_idx    (rd_idx)
    );

    // Clearing sweep after reset: one entry of both lines per clock.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end else if (clear_busy_reg) begin
            clear_cnt_reg <= clear_cnt_reg + AW'(1);
            if (clear_cnt_reg == POS_LAST) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // Line RAMs: read at the delayed index, write back at the write position.
    crdr_line_ram #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_forward_line (
        .aclk    (aclk),
        .rd_en   (en),
        .rd_addr (rd_idx),
        .rd_data (fwd_rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (fwd_wr_data)
    );

    crdr_line_ram #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_return_line (
        .aclk    (aclk),
        .rd_en   (en),
        .rd_addr (rd_idx),
        .rd_data (ret_rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ret_wr_data)
    );

    // Stage 4 control: note whether this read meets the write of the beat ahead
    // (which lands in the same cycle) or the beat's own write position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg    <= 1'b0;
            s4_fwd_hit_reg  <= 1'b0;
            s4_self_hit_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg    <= rd_valid;
            s4_fwd_hit_reg  <= s4_valid_reg && (s4_pos_reg == rd_idx);
            s4_self_hit_reg <= (rd_pos == rd_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_sample_reg  <= rd_sample;
            s4_pos_reg     <= rd_pos;
            s4_fwd_fwd_reg <= fwd_wdata;
            s4_fwd_ret_reg <= tap;
        end
    end

    // Mix: tap from the forward line feeds the return line, whose delayed
    // value is fed back with the input into the forward line.
    always_comb begin
        fwd_val = s4_fwd_hit_reg ? s4_fwd_fwd_reg : signed'(fwd_rd_data);
        tap     = crdr_pkg::half_floor(fwd_val);
        if (s4_self_hit_reg) begin
            ret_val = tap;
        end else if (s4_fwd_hit_reg) begin
            ret_val = s4_fwd_ret_reg;
        end else begin
            ret_val = signed'(ret_rd_data);
        end
        fwd_wdata = crdr_pkg::sat_add(s4_sample_reg, crdr_pkg::half_floor(ret_val));
        result    = crdr_pkg::sat_add(s4_sample_reg, crdr_pkg::half_floor(tap));
    end

    // Write-back, or zeros while the sweep runs.
    always_comb begin
        wr_en       = clear_busy_reg || (en && s4_valid_reg);
        wr_addr     = clear_busy_reg ? clear_cnt_reg : s4_pos_reg;
        fwd_wr_data = clear_busy_reg ? '0 : fwd_wdata;
        ret_wr_data = clear_busy_reg ? '0 : tap;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s4_valid_reg) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // No beat enters while the lines are being swept.
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !s_tready)
        else $error("beat accepted during line clear");

    // The sweep and the write-back never contend for the write port.
    a_no_wb_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !s4_valid_reg)
        else $error("write-back during line clear");

    // The previous beat's position and this beat's own position never coincide.
    a_hit_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_valid_reg && s4_fwd_hit_reg) |-> !s4_self_hit_reg)
        else $error("forward and self hit at once");

    // A beat in the mix stage leaves it when the output register is free or being drained.
    a_mix_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_valid_reg && en) |=> m_tvalid)
        else $error("mixed beat did not reach output");

endmodule

`default_nettype wire

### hw/rtl/crdr_line_ram.sv
// One circular line: a single-port-write, single-port-read synchronous RAM.
// Read data is registered. Uses crdr_pkg for widths.
`default_nettype none

module crdr_line_ram #(
    parameter int LINE_DEPTH = crdr_pkg::LINE_DEPTH_DEF,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [crdr_pkg::SAMPLE_W-1:0] rd_data,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [crdr_pkg::SAMPLE_W-1:0] wr_data
);

    logic [crdr_pkg::SAMPLE_W-1:0] mem [LINE_DEPTH];
    logic [crdr_pkg::SAMPLE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a read that meets a write to the same entry returns the old data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/crdr_addr_gen.sv
// Address front end: write position counter, knob scaling and read index.
// Three pipeline stages advanced by a shared enable. Uses crdr_pkg.
`default_nettype none

module crdr_addr_gen #(
    parameter int LINE_DEPTH = crdr_pkg::LINE_DEPTH_DEF,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire logic                                 in_accept,
    input  wire logic signed [crdr_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic        [crdr_pkg::KNOB_W-1:0]   in_knob,
    output logic                                      rd_valid,
    output logic signed      [crdr_pkg::SAMPLE_W-1:0] rd_sample,
    output logic             [AW-1:0]                 rd_pos,
    output logic             [AW-1:0]                 rd_idx
);

    localparam int PW = crdr_pkg::KNOB_W + AW;

    localparam logic [AW-1:0] POS_LAST  = AW'(LINE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(LINE_DEPTH);
    localparam logic [PW-1:0] SCALE     = PW'(LINE_DEPTH - 1);

    logic [AW-1:0] wp_reg, wp_next;

    logic                                 s1_valid_reg;
    logic signed [crdr_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic        [crdr_pkg::KNOB_W-1:0]   s1_knob_reg;
    logic        [AW-1:0]                 s1_pos_reg;
    logic        [crdr_pkg::KNOB_W-1:0]   s1_knob_next;

    logic                                 s2_valid_reg;
    logic signed [crdr_pkg::SAMPLE_W-1:0] s2_sample_reg;
    logic        [PW-1:0]                 s2_prod_reg;
    logic        [AW-1:0]                 s2_pos_reg;
    logic        [PW-1:0]                 s2_prod_next;

    logic                                 s3_valid_reg;
    logic signed [crdr_pkg::SAMPLE_W-1:0] s3_sample_reg;
    logic        [AW-1:0]                 s3_pos_reg;
    logic        [AW-1:0]                 s3_idx_reg;
    logic        [AW-1:0]                 s3_idx_next;

    logic [AW:0] delay;
    logic [AW:0] idx_sum;

    // Write position wraps at the line depth and moves once per accepted beat.
    always_comb begin
        wp_next = (wp_reg == POS_LAST) ? '0 : wp_reg + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else if (in_accept) begin
            wp_reg <= wp_next;
        end
    end

    // Stage 1: capture the beat, with knob values above one held at one.
    always_comb begin
        s1_knob_next = (in_knob > crdr_pkg::KNOB_ONE) ? crdr_pkg::KNOB_ONE : in_knob;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sample_reg <= in_sample;
            s1_knob_reg   <= s1_knob_next;
            s1_pos_reg    <= wp_reg;
        end
    end

    // Stage 2: scale the knob by the depth minus one.
    always_comb begin
        s2_prod_next = PW'(s1_knob_reg) * SCALE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sample_reg <= s1_sample_reg;
            s2_prod_reg   <= s2_prod_next;
            s2_pos_reg    <= s1_pos_reg;
        end
    end

    // Stage 3: the delay runs from one to the depth; step back from the write position.
    always_comb begin
        delay   = {1'b0, s2_prod_reg[crdr_pkg::KNOB_FRAC +: AW]} + (AW + 1)'(1);
        idx_sum = {1'b0, s2_pos_reg} + DEPTH_EXT - delay;
        if (idx_sum >= DEPTH_EXT) begin
            s3_idx_next = AW'(idx_sum - DEPTH_EXT);
        end else begin
            s3_idx_next = idx_sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sample_reg <= s2_sample_reg;
            s3_pos_reg    <= s2_pos_reg;
            s3_idx_reg    <= s3_idx_next;
        end
    end

    assign rd_valid  = s3_valid_reg;
    assign rd_sample = s3_sample_reg;
    assign rd_pos    = s3_pos_reg;
    assign rd_idx    = s3_idx_reg;

    // The write position never leaves the line.
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= POS_LAST)
        else $error("write position beyond line depth");

    // A read index handed to the lines always lies inside them.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_idx_reg <= POS_LAST))
        else $error("read index beyond line depth");

endmodule

`default_nettype wire
